FILE: rtl/sha_pkg.sv
// Shared constants, types and round functions for the SHA-256 stream hasher.
package sha_pkg;

   localparam int unsigned WordWidth = 32;

   typedef logic [WordWidth-1:0] word_type;

   typedef struct packed {
      logic     load;      // load working variables from chaining value
      logic     step;      // perform one round
      logic [5:0] round;   // round number 0..63
      word_type w;         // message schedule word for this round
   } round_ctrl_type;

   localparam word_type RoundK [64] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type InitH [8] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   localparam logic [7:0] PadByte = 8'h80;

   function automatic word_type ror(input word_type x, input int unsigned n);
      ror = (x >> n) | (x << (WordWidth - n));
   endfunction

endpackage

FILE: rtl/sha256_stream_hasher.sv
// Top level of the streaming SHA-256 hasher: byte packing, padding, sequencer, output.
// Usage:
//   req_ channel carries one message byte per request (tdata) with a present
//   flag (tuser) and an end-of-message mark (tlast). rsp_ channel returns the
//   eight digest words, word 0 first, tlast on the eighth.
// Timing:
//   A plain byte is taken while idle unless it fills the block; a full block then
//   runs 64 rounds of the single shared round unit between a load and a fold
//   step, and req_tready stays low throughout. On end of message the padding
//   bytes are fed through the same byte path, one per cycle except while a full
//   block is compressed; then one or two compressions run and the eight words
//   are offered one per cycle; each waits while rsp_tready is low.
//   The block takes no new request until the last digest word is taken.
// Reset:
//   reset (synchronous) restores the initial hash value and clears the byte
//   count and position; no clearing pass is needed.
module sha256_stream_hasher (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // byte_present
   input  logic        req_tlast,   // end_of_message
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast    // last_word
);
   import sha_pkg::*;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_LOAD  = 6'b000010,
      S_ROUND = 6'b000100,
      S_FOLD  = 6'b001000,
      S_PAD   = 6'b010000,
      S_OUT   = 6'b100000
   } state_type;

   state_type   state_ff, state_in;
   word_type    hash_ff [8];
   word_type    hash_in [8];
   word_type    buf_ff [16];
   word_type    buf_in [16];
   logic [60:0] count_ff, count_in;
   logic [5:0]  pos_ff, pos_in;
   logic [5:0]  round_ff, round_in;
   logic        pad_ff, pad_in;       // padding run active
   logic        mark_ff, mark_in;     // 0x80 marker still to write
   logic [3:0]  padn_ff, padn_in;     // length-byte progress, 9 once all eight length bytes are written
   logic [2:0]  oidx_ff, oidx_in;
   logic        put;
   logic [7:0]  put_byte;
   logic [63:0] bits;
   word_type    w;
   word_type    vars [8];
   round_ctrl_type ctrl;

   assign bits = {count_ff, 3'b000};

   sha_sched u_sched (
      .clock(clock), .load(state_ff == S_LOAD), .step(state_ff == S_ROUND),
      .block_in(buf_ff), .w_out(w)
   );

   always_comb begin
      ctrl.load  = (state_ff == S_LOAD);
      ctrl.step  = (state_ff == S_ROUND);
      ctrl.round = round_ff;
      ctrl.w     = w;
   end

   sha_round u_round (.clock(clock), .ctrl(ctrl), .hash_in(hash_ff), .vars_out(vars));

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign rsp_tdata  = hash_ff[oidx_ff];
   assign rsp_tuser  = oidx_ff;
   assign rsp_tlast  = (oidx_ff == 3'd7);

   always_comb begin
      state_in = state_ff;
      hash_in  = hash_ff;
      buf_in   = buf_ff;
      count_in = count_ff;
      pos_in   = pos_ff;
      round_in = round_ff;
      pad_in   = pad_ff;
      mark_in  = mark_ff;
      padn_in  = padn_ff;
      oidx_in  = oidx_ff;
      put      = 1'b0;
      put_byte = req_tdata;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               put = req_tuser;
               if (req_tuser) count_in = count_ff + 61'd1;
               if (req_tlast) begin
                  pad_in  = 1'b1;
                  mark_in = 1'b1;
                  padn_in = '0;
               end
            end
         end
         S_PAD: begin
            put = 1'b1;
            if (padn_ff == 4'd0 && mark_ff) begin
               put_byte = PadByte;
               mark_in  = 1'b0;
               if (pos_ff == 6'd55) padn_in = 4'd1;
            end else if (padn_ff == 4'd0 && pos_ff != 6'd56) begin
               put_byte = 8'h00;
            end else if (padn_ff == 4'd0) begin
               put_byte = bits[63:56];
               padn_in  = 4'd2;
            end else begin
               put_byte = 8'(bits >> (7'd64 - 7'({padn_ff, 3'b000})));
               padn_in  = padn_ff + 4'd1;
            end
            if (padn_ff == 4'd1) begin
               put_byte = bits[63:56];
               padn_in  = 4'd2;
            end
         end
         S_LOAD: begin
            round_in = '0;
            state_in = S_ROUND;
         end
         S_ROUND: begin
            round_in = round_ff + 6'd1;
            if (round_ff == 6'd63) state_in = S_FOLD;
         end
         S_FOLD: begin
            for (int i = 0; i < 8; i++) hash_in[i] = hash_ff[i] + vars[i];
            if (padn_ff == 4'd9) begin
               oidx_in  = '0;
               state_in = S_OUT;
            end else if (pad_ff) begin
               state_in = S_PAD;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               oidx_in = oidx_ff + 3'd1;
               if (oidx_ff == 3'd7) begin
                  hash_in  = InitH;
                  count_in = '0;
                  pos_in   = '0;
                  pad_in   = 1'b0;
                  padn_in  = '0;
                  state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (put) begin
         buf_in[pos_ff[5:2]][{~pos_ff[1:0], 3'b000} +: 8] = put_byte;
         pos_in = pos_ff + 6'd1;
      end
      // next state after a byte write or an end mark
      if ((state_ff == S_IDLE && req_tvalid) || state_ff == S_PAD) begin
         if (put && pos_ff == 6'd63) state_in = S_LOAD;
         else if (state_ff == S_PAD || req_tlast) state_in = S_PAD;
         else state_in = S_IDLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         hash_ff  <= InitH;
         count_ff <= '0;
         pos_ff   <= '0;
         pad_ff   <= 1'b0;
         mark_ff  <= 1'b0;
         padn_ff  <= '0;
         oidx_ff  <= '0;
      end else begin
         state_ff <= state_in;
         hash_ff  <= hash_in;
         count_ff <= count_in;
         pos_ff   <= pos_in;
         pad_ff   <= pad_in;
         mark_ff  <= mark_in;
         padn_ff  <= padn_in;
         oidx_ff  <= oidx_in;
      end
   end

   always_ff @(posedge clock) begin
      buf_ff   <= buf_in;
      round_ff <= round_in;
   end

   a_round_wrap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ROUND && round_ff == 6'd63) |=> state_ff == S_FOLD)
      else $error("round count did not end compression");
   a_out_start: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_OUT) ##1 (state_ff == S_OUT) |-> oidx_ff == 3'd0)
      else $error("digest output did not start at word 0");
   a_out_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> state_ff == S_IDLE && pos_ff == 6'd0)
      else $error("hasher not reset after digest");
endmodule

FILE: rtl/sha_sched.sv
// Message schedule: 16-word circular window producing one W word per round.
module sha_sched (
   input  logic              clock,
   input  logic              load,
   input  logic              step,
   input  sha_pkg::word_type block_in [16],
   output sha_pkg::word_type w_out
);
   import sha_pkg::*;

   word_type win_ff [16];
   word_type win_in [16];
   word_type s0, s1, w_new;

   assign w_out = win_ff[0];

   always_comb begin
      s0 = ror(win_ff[1], 7) ^ ror(win_ff[1], 18) ^ (win_ff[1] >> 3);
      s1 = ror(win_ff[14], 17) ^ ror(win_ff[14], 19) ^ (win_ff[14] >> 10);
      w_new = win_ff[0] + s0 + win_ff[9] + s1;
      win_in = win_ff;
      if (load) begin
         win_in = block_in;
      end else if (step) begin
         for (int i = 0; i < 15; i++) win_in[i] = win_ff[i+1];
         win_in[15] = w_new;
      end
   end

   always_ff @(posedge clock) begin
      win_ff <= win_in;
   end
endmodule

FILE: rtl/sha_round.sv
// Shared round unit: working variables a..h updated one round per cycle while step is set.
module sha_round (
   input  logic                   clock,
   input  sha_pkg::round_ctrl_type ctrl,
   input  sha_pkg::word_type      hash_in [8],
   output sha_pkg::word_type      vars_out [8]
);
   import sha_pkg::*;

   word_type v_ff [8];
   word_type v_in [8];
   word_type ch, mj, e1, e0, t1, t2;

   assign vars_out = v_ff;

   always_comb begin
      ch = (v_ff[4] & v_ff[5]) ^ (~v_ff[4] & v_ff[6]);
      mj = (v_ff[0] & v_ff[1]) ^ (v_ff[0] & v_ff[2]) ^ (v_ff[1] & v_ff[2]);
      e1 = ror(v_ff[4], 6) ^ ror(v_ff[4], 11) ^ ror(v_ff[4], 25);
      e0 = ror(v_ff[0], 2) ^ ror(v_ff[0], 13) ^ ror(v_ff[0], 22);
      t1 = v_ff[7] + e1 + ch + RoundK[ctrl.round] + ctrl.w;
      t2 = e0 + mj;
      v_in = v_ff;
      if (ctrl.load) begin
         v_in = hash_in;
      end else if (ctrl.step) begin
         v_in[7] = v_ff[6];
         v_in[6] = v_ff[5];
         v_in[5] = v_ff[4];
         v_in[4] = v_ff[3] + t1;
         v_in[3] = v_ff[2];
         v_in[2] = v_ff[1];
         v_in[1] = v_ff[0];
         v_in[0] = t1 + t2;
      end
   end

   always_ff @(posedge clock) begin
      v_ff <= v_in;
   end
endmodule
